// ===== rtl/seqr_pkg.sv =====
// Shared types and constants for the sequence resequencer.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package seqr_pkg;

	localparam int SEQ_W      = 32;
	localparam int PAY_W      = 32;
	localparam int STAT_W     = 2;
	localparam int WINDOW_DEF = 32;
	localparam int QDEPTH     = 2;
	localparam int S_TDATA_W  = 72;
	localparam int M_TDATA_W  = 72;

	// Item operation held in the queue
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_SET  = 1'b1;

	// Result kind
	localparam logic KIND_MSG = 1'b0;
	localparam logic KIND_ACK = 1'b1;

	// Acknowledgment status
	localparam logic [STAT_W-1:0] STAT_INORDER = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EARLY   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_STALE   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FAR     = 2'd3;

	typedef struct packed {
		logic             op;
		logic [SEQ_W-1:0] seq;
		logic [PAY_W-1:0] payload;
		logic             has_text;
	} item_t;

endpackage

// ===== rtl/seqr_front.sv =====
// Front end: accepts input words, tracks the joined flag and drops packets
// that are ignored. Depends on seqr_pkg; feeds seqr_queue.
`timescale 1ns / 1ps

module seqr_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [seqr_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                           s_tuser,
	input  logic                           q_full,
	output logic                           q_push,
	output seqr_pkg::item_t                q_item
);
	import seqr_pkg::*;

	logic joined_q;
	logic acc;
	logic lead;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && !q_full;
	assign lead     = s_tdata[SEQ_W];

	assign q_item.op       = s_tuser;
	assign q_item.seq      = s_tdata[SEQ_W-1:0];
	assign q_item.payload  = s_tdata[SEQ_W+PAY_W:SEQ_W+1];
	assign q_item.has_text = s_tdata[SEQ_W+PAY_W+1];

	// Set-sequence words always pass; data words only once joined and from the leader.
	assign q_push = acc && ((s_tuser == OP_SET) || (joined_q && lead));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joined_q <= 1'b0;
		end else if (acc && s_tuser == OP_SET) begin
			joined_q <= 1'b1;
		end
	end

endmodule

// ===== rtl/seqr_queue.sv =====
// Short queue between the front end and the back end.
// Depends on seqr_pkg for the item type and depth.
`timescale 1ns / 1ps

module seqr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  seqr_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output seqr_pkg::item_t head
);
	import seqr_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	item_t         q_mem [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   cnt_q;

	assign full  = (cnt_q == (PW+1)'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign head  = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(QDEPTH))
		else $error("queue count exceeds its depth");

endmodule

// ===== rtl/seqr_back.sv =====
// Back end: executes set-sequence and data items, holds the reorder window
// and drives the output register. Depends on seqr_pkg; fed by seqr_queue.
`timescale 1ns / 1ps

module seqr_back #(
	parameter int WINDOW = seqr_pkg::WINDOW_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  seqr_pkg::item_t                q_item,
	output logic                           q_pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [seqr_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tuser,
	output logic                           m_tlast
);
	import seqr_pkg::*;

	localparam int IW    = (WINDOW > 2) ? $clog2(WINDOW) : 1;
	localparam int M_PAD = M_TDATA_W - SEQ_W - PAY_W - STAT_W;
	localparam int RSH   = SEQ_W - 1 + $clog2(WINDOW);

	localparam logic [IW:0]        WIN_W    = (IW+1)'(WINDOW);
	localparam logic [IW-1:0]      IDX_LAST = IW'(WINDOW - 1);
	localparam logic [IW-1:0]      DRN_LAST = IW'(WINDOW - 2);
	localparam logic [SEQ_W-1:0]   WIN_SEQ  = SEQ_W'(WINDOW);
	localparam logic [2*SEQ_W-1:0] RCP_WIDE = ((2*SEQ_W)'(1) << RSH) / (2*SEQ_W)'(WINDOW);
	localparam logic [SEQ_W-1:0]   RCP      = SEQ_W'(RCP_WIDE);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SET   = 3'd1;
	localparam logic [2:0] S_CLASS = 3'd2;
	localparam logic [2:0] S_DRD   = 3'd3;
	localparam logic [2:0] S_DCHK  = 3'd4;
	localparam logic [2:0] S_ACK   = 3'd5;
	localparam logic [2:0] S_REM   = 3'd6;

	typedef struct packed {
		logic [SEQ_W-1:0] tag;
		logic             has_text;
		logic [PAY_W-1:0] payload;
	} slot_t;

	logic [2:0]        state_q;
	item_t             it_q;
	logic [SEQ_W-1:0]  exp_q;
	logic [IW-1:0]     exp_idx_q;
	logic [WINDOW-1:0] valid_q;
	slot_t             slot_mem [WINDOW];
	slot_t             rd_q;
	logic [IW-1:0]     drn_cnt_q;
	logic [STAT_W-1:0] stat_q;
	logic [SEQ_W-1:0]  quo_q;

	logic              m_valid_q;
	logic              m_kind_q;
	logic [SEQ_W-1:0]  m_seq_q;
	logic [PAY_W-1:0]  m_pay_q;
	logic [STAT_W-1:0] m_stat_q;
	logic              m_last_q;

	logic               can_emit;
	logic [SEQ_W-1:0]   exp_nxt;
	logic [IW-1:0]      idx_nxt;
	logic               in_order;
	logic [SEQ_W-1:0]   diff;
	logic               is_ahead;
	logic               is_near;
	logic [IW:0]        st_sum;
	logic [IW:0]        st_wrap;
	logic [IW-1:0]      st_idx;
	logic               store_en;
	logic               hit;
	logic               dchk_go;
	logic               class_go;
	logic [2*SEQ_W-1:0] rcp_prod;
	logic [2*SEQ_W-1:0] rcp_sh;
	logic [SEQ_W-1:0]   rem_est;
	logic [IW:0]        rem_lo;
	logic [IW:0]        rem_fix;

	logic              emit;
	logic              e_kind;
	logic [SEQ_W-1:0]  e_seq;
	logic [PAY_W-1:0]  e_pay;
	logic [STAT_W-1:0] e_stat;
	logic              e_last;

	assign can_emit = !m_valid_q || m_tready;
	assign q_pop    = (state_q == S_IDLE) && q_valid;

	// The slot index follows expected_seq; wrapping of the 32-bit count restarts it at zero.
	assign exp_nxt = exp_q + 1'b1;
	assign idx_nxt = (exp_q == '1 || exp_idx_q == IDX_LAST) ? '0 : exp_idx_q + 1'b1;

	assign in_order = (it_q.seq == exp_q) || (exp_q == '0);
	assign diff     = it_q.seq - exp_q;
	assign is_ahead = it_q.seq > exp_q;
	assign is_near  = diff < WIN_SEQ;

	// An early packet lies less than one window ahead, so its slot is one add and wrap away.
	assign st_sum   = {1'b0, exp_idx_q} + {1'b0, diff[IW-1:0]};
	assign st_wrap  = st_sum - WIN_W;
	assign st_idx   = (st_sum >= WIN_W) ? st_wrap[IW-1:0] : st_sum[IW-1:0];
	assign store_en = (state_q == S_CLASS) && !in_order && is_ahead && is_near;

	assign hit      = valid_q[exp_idx_q] && (rd_q.tag == exp_q);
	assign dchk_go  = !rd_q.has_text || can_emit;
	assign class_go = !it_q.has_text || can_emit;

	// Remainder of a newly set expected number by the window. A 32 by 32 reciprocal
	// product gives a quotient that is at most one short, so one subtract corrects it.
	assign rcp_prod = (2*SEQ_W)'(exp_q) * (2*SEQ_W)'(RCP);
	assign rcp_sh   = rcp_prod >> RSH;
	assign rem_est  = exp_q - quo_q * WIN_SEQ;
	assign rem_lo   = rem_est[IW:0];
	assign rem_fix  = (rem_lo >= WIN_W) ? (rem_lo - WIN_W) : rem_lo;

	always_comb begin
		emit   = 1'b0;
		e_kind = KIND_MSG;
		e_seq  = it_q.seq;
		e_pay  = it_q.payload;
		e_stat = STAT_INORDER;
		e_last = 1'b0;
		unique case (state_q)
			S_CLASS: begin
				emit = in_order && it_q.has_text && can_emit;
			end
			S_DCHK: begin
				emit  = hit && rd_q.has_text && can_emit;
				e_seq = exp_q;
				e_pay = rd_q.payload;
			end
			S_ACK: begin
				emit   = can_emit;
				e_kind = KIND_ACK;
				e_pay  = '0;
				e_stat = stat_q;
				e_last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			exp_q     <= '0;
			exp_idx_q <= '0;
			valid_q   <= '0;
			drn_cnt_q <= '0;
			stat_q    <= STAT_INORDER;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_item.op == OP_SET) begin
							exp_q   <= q_item.seq;
							state_q <= S_SET;
						end else begin
							state_q <= S_CLASS;
						end
					end
				end
				S_SET: begin
					state_q <= S_REM;
				end
				S_REM: begin
					exp_idx_q <= rem_fix[IW-1:0];
					state_q   <= S_IDLE;
				end
				S_CLASS: begin
					priority if (in_order) begin
						if (class_go) begin
							exp_q     <= exp_nxt;
							exp_idx_q <= idx_nxt;
							drn_cnt_q <= '0;
							stat_q    <= STAT_INORDER;
							state_q   <= S_DRD;
						end
					end else if (store_en) begin
						valid_q[st_idx] <= 1'b1;
						stat_q          <= STAT_EARLY;
						state_q         <= S_ACK;
					end else if (is_ahead) begin
						stat_q  <= STAT_FAR;
						state_q <= S_ACK;
					end else begin
						stat_q  <= STAT_STALE;
						state_q <= S_ACK;
					end
				end
				S_DRD: begin
					state_q <= S_DCHK;
				end
				S_DCHK: begin
					if (!hit) begin
						state_q <= S_ACK;
					end else if (dchk_go) begin
						valid_q[exp_idx_q] <= 1'b0;
						exp_q              <= exp_nxt;
						exp_idx_q          <= idx_nxt;
						drn_cnt_q          <= drn_cnt_q + 1'b1;
						state_q            <= (drn_cnt_q == DRN_LAST) ? S_ACK : S_DRD;
					end
				end
				S_ACK: begin
					if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			it_q <= q_item;
		end
		if (state_q == S_SET) begin
			quo_q <= rcp_sh[SEQ_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			slot_mem[st_idx] <= '{tag: it_q.seq, has_text: it_q.has_text, payload: it_q.payload};
		end
		rd_q <= slot_mem[exp_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_kind_q <= e_kind;
			m_seq_q  <= e_seq;
			m_pay_q  <= e_pay;
			m_stat_q <= e_stat;
			m_last_q <= e_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {{M_PAD{1'b0}}, m_stat_q, m_pay_q, m_seq_q};

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		exp_idx_q <= IDX_LAST)
		else $error("slot index of the expected number left the window");

	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DCHK) |-> (drn_cnt_q <= DRN_LAST))
		else $error("drain walk ran past its bound");

	a_ack_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACK && can_emit) |=> (m_valid_q && m_last_q && m_kind_q == KIND_ACK))
		else $error("acknowledgment word not loaded at the end of an item");

	a_slot_freed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DCHK && hit && dchk_go) |=> !valid_q[$past(exp_idx_q)])
		else $error("drained slot still marked valid");

endmodule

// ===== rtl/sequence_resequencer_core.sv =====
// Top level of the sequence resequencer: front end, item queue and back end.
// Depends on seqr_pkg, seqr_front, seqr_queue and seqr_back.
//
//  Port group  Dir  tdata (low bit up)                          tuser     tlast
//  s_*         in   seq_num, from_leader, payload, has_text     req_type  -
//  m_*         out  seq_out, payload_out, status                kind      last
//
// An early, stale or far packet passes fetch, classify and ack in the back end; an
// in-order one also passes a slot read and check, repeated for each buffered packet
// drained, and the walk stops at its bound of WINDOW-1 packets.
// A set-sequence word passes fetch, reciprocal multiply and remainder.
// Reset is asynchronous and active low; no clearing pass is needed. A low m_tready
// holds the back end in classify, check or ack, and the two-entry queue and the output
// register let the front end go on accepting words in the meantime.
`timescale 1ns / 1ps

module sequence_resequencer_core #(
	parameter int WINDOW = seqr_pkg::WINDOW_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// seq_num[31:0], from_leader[32], payload[64:33], has_text[65], zero fill
	input  logic [seqr_pkg::S_TDATA_W-1:0] s_tdata,
	// req_type
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// seq_out[31:0], payload_out[63:32], status[65:64], zero fill
	output logic [seqr_pkg::M_TDATA_W-1:0] m_tdata,
	// kind
	output logic                           m_tuser,
	output logic                           m_tlast
);
	import seqr_pkg::*;

	item_t push_item;
	item_t head_item;
	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_valid;

	seqr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	seqr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (head_item)
	);

	seqr_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (head_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== dv/tb_sequence_resequencer_core.sv =====
// Self-checking testbench for sequence_resequencer_core: a tracker class predicts
// every delivered word and acknowledgment, and a monitor compares them as they leave.
// Depends on seqr_pkg and the RTL of sequence_resequencer_core.
`timescale 1ns / 1ps

module tb_sequence_resequencer_core;

	import seqr_pkg::*;

	localparam int WIN         = WINDOW_DEF;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 350;

	typedef struct packed {
		logic              kind;
		logic [SEQ_W-1:0]  seq;
		logic [PAY_W-1:0]  pay;
		logic [STAT_W-1:0] status;
		logic              last;
	} reseq_word_t;

	// Tracks the receive-side ordering state and the words it must produce.
	class resequencer_tracker;
		logic [SEQ_W-1:0] expected_seq;
		logic             joined;
		logic [WIN-1:0]   slot_full;
		logic [SEQ_W-1:0] slot_tag [WIN];
		logic [PAY_W:0]   slot_body [WIN];
		reseq_word_t      due [$];
		int               failures;
		int               words_seen;

		function new();
			expected_seq = '0;
			joined       = 1'b0;
			slot_full    = '0;
			failures     = 0;
			words_seen   = 0;
		endfunction

		function void await_word(logic kind, logic [SEQ_W-1:0] seq, logic [PAY_W-1:0] pay,
				logic [STAT_W-1:0] status, logic last);
			reseq_word_t w;
			w.kind   = kind;
			w.seq    = seq;
			w.pay    = pay;
			w.status = status;
			w.last   = last;
			due.insert(due.size(), w);
		endfunction

		// Returns 1 when the item changes state or causes words, 0 when it is ignored.
		function bit take_input(logic req, logic [SEQ_W-1:0] seq, logic lead,
				logic [PAY_W-1:0] pay, logic text);
			int unsigned       idx;
			logic [SEQ_W-1:0]  ahead;
			logic [STAT_W-1:0] status;
			if (req == OP_SET) begin
				expected_seq = seq;
				joined       = 1'b1;
				return 1'b1;
			end
			if (!joined || !lead)
				return 1'b0;
			if (seq == expected_seq || expected_seq == '0) begin
				if (text)
					await_word(KIND_MSG, seq, pay, STAT_INORDER, 1'b0);
				expected_seq = expected_seq + 1'b1;
				// At most WIN-1 buffered words drain behind one in-order packet.
				for (int k = 0; k < WIN - 1; k++) begin
					idx = expected_seq % WIN;
					if (!slot_full[idx] || slot_tag[idx] != expected_seq)
						break;
					if (slot_body[idx][PAY_W])
						await_word(KIND_MSG, expected_seq, slot_body[idx][PAY_W-1:0],
							STAT_INORDER, 1'b0);
					slot_full[idx] = 1'b0;
					expected_seq   = expected_seq + 1'b1;
				end
				status = STAT_INORDER;
			end else if (seq > expected_seq) begin
				ahead = seq - expected_seq;
				if (ahead >= WIN) begin
					status = STAT_FAR;
				end else begin
					idx            = seq % WIN;
					slot_tag[idx]  = seq;
					slot_body[idx] = {text, pay};
					slot_full[idx] = 1'b1;
					status         = STAT_EARLY;
				end
			end else begin
				status = STAT_STALE;
			end
			await_word(KIND_ACK, seq, '0, status, 1'b1);
			return 1'b1;
		endfunction

		function void check_word(logic kind, logic [M_TDATA_W-1:0] data, logic last);
			reseq_word_t got;
			reseq_word_t want;
			string       want_s;
			string       got_s;
			got.kind   = kind;
			got.seq    = data[SEQ_W-1:0];
			got.pay    = data[SEQ_W+PAY_W-1:SEQ_W];
			got.status = data[SEQ_W+PAY_W+STAT_W-1:SEQ_W+PAY_W];
			got.last   = last;
			words_seen++;
			if (due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected word: kind %0d seq %h payload %h status %0d last %0d",
						got.kind, got.seq, got.pay, got.status, got.last);
				return;
			end
			want = due.pop_front();
			if (got.kind !== want.kind || got.seq !== want.seq || got.pay !== want.pay ||
					got.status !== want.status || got.last !== want.last) begin
				failures++;
				if (failures <= 10) begin
					want_s = $sformatf("kind %0d seq %h payload %h status %0d last %0d",
						want.kind, want.seq, want.pay, want.status, want.last);
					got_s  = $sformatf("kind %0d seq %h payload %h status %0d last %0d",
						got.kind, got.seq, got.pay, got.status, got.last);
					$display("mismatch: expected %s, got %s", want_s, got_s);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;

	resequencer_tracker tracker;
	int                 burst_left;
	int                 fed;
	int                 stalled_cycles;
	bit                 held_off;

	sequence_resequencer_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offers one word, with a random gap at the start of each burst, and waits for it
	// to be taken.
	task automatic send_word(input logic req, input logic [SEQ_W-1:0] seq, input logic lead,
			input logic [PAY_W-1:0] pay, input logic text);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {{(S_TDATA_W - SEQ_W - PAY_W - 2){1'b0}}, text, pay, lead, seq};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (tracker.take_input(req, seq, lead, pay, text))
			fed++;
	endtask

	// Words that break an ordered run: other senders, old, far-off, early or random numbers, and set-sequence words.
	task automatic send_noise();
		case ($urandom_range(0, 5))
			0: send_word(OP_DATA, $urandom, 1'b0, $urandom, 1'($urandom_range(0, 1)));
			1: send_word(OP_DATA, tracker.expected_seq - 1 - $urandom_range(0, 200), 1'b1,
				$urandom, 1'b1);
			2: send_word(OP_DATA, tracker.expected_seq + WIN + $urandom_range(0, 1000), 1'b1,
				$urandom, 1'b1);
			3: send_word(OP_DATA, $urandom, 1'b1, $urandom, 1'($urandom_range(0, 1)));
			4: send_word(OP_SET, $urandom, 1'($urandom_range(0, 1)), $urandom,
				1'($urandom_range(0, 1)));
			default: send_word(OP_DATA, tracker.expected_seq + $urandom_range(1, WIN - 1), 1'b1,
				$urandom, 1'($urandom_range(0, 1)));
		endcase
	endtask

	// One run of consecutive numbers sent out of order. In the overflow form a full
	// window is buffered behind a word that is one further on, so the drain stops at
	// its bound and leaves that word behind.
	task automatic run_episode(input bit overflow);
		logic [SEQ_W-1:0] base;
		logic [SEQ_W-1:0] tmp;
		logic [SEQ_W-1:0] run [$];
		int               n;
		int               pick;
		if (overflow) begin
			base = $urandom;
			send_word(OP_SET, base + 1, 1'b0, '0, 1'b0);
			send_word(OP_DATA, base + WIN, 1'b1, $urandom, 1'b1);
			send_word(OP_SET, base, 1'b1, '0, 1'b0);
			n = WIN;
		end else begin
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 3))
					0: base = '0;
					1: base = 32'hFFFF_FFFF - $urandom_range(0, 12);
					2: base = tracker.expected_seq + $urandom_range(0, 40);
					default: base = $urandom;
				endcase
				send_word(OP_SET, base, 1'($urandom_range(0, 1)), $urandom,
					1'($urandom_range(0, 1)));
			end
			base = tracker.expected_seq;
			n = ($urandom_range(0, 11) == 0) ? $urandom_range(24, 36) : $urandom_range(1, 10);
		end
		for (int j = 1; j < n; j++)
			run.insert(run.size(), base + j);
		for (int j = run.size() - 1; j > 0; j--) begin
			pick      = $urandom_range(0, j);
			tmp       = run[j];
			run[j]    = run[pick];
			run[pick] = tmp;
		end
		if (overflow)
			run.insert(run.size(), base);
		else
			run.insert($urandom_range(0, run.size()), base);
		foreach (run[j]) begin
			if (!overflow && $urandom_range(0, 5) == 0)
				send_noise();
			send_word(OP_DATA, run[j], 1'b1, $urandom, $urandom_range(0, 3) != 0);
		end
	endtask

	initial begin
		int episode;
		tracker    = new();
		burst_left = 0;
		fed        = 0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = OP_DATA;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ignored before joining, then a join taken from a non-leader.
		send_word(OP_DATA, 32'd5, 1'b1, 32'h0000_0005, 1'b1);
		send_word(OP_SET, 32'd0, 1'b0, '0, 1'b0);
		// Expected number zero takes any packet; extremes of number and payload.
		send_word(OP_DATA, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
		send_word(OP_DATA, 32'd1, 1'b0, 32'h1111_1111, 1'b1);
		send_word(OP_DATA, 32'd1, 1'b1, 32'h0000_0000, 1'b0);
		// Early words, a duplicate, the window edge, far and stale, then the drain.
		send_word(OP_SET, 32'd100, 1'b1, '0, 1'b0);
		send_word(OP_DATA, 32'd102, 1'b1, 32'hAAAA_0102, 1'b1);
		send_word(OP_DATA, 32'd103, 1'b1, 32'hAAAA_0103, 1'b0);
		send_word(OP_DATA, 32'd101, 1'b1, 32'hAAAA_0101, 1'b1);
		send_word(OP_DATA, 32'd102, 1'b1, 32'h5555_0102, 1'b1);
		send_word(OP_DATA, 32'd100 + WIN - 1, 1'b1, 32'hAAAA_0131, 1'b1);
		send_word(OP_DATA, 32'd100 + WIN, 1'b1, 32'hAAAA_0132, 1'b1);
		send_word(OP_DATA, 32'd50, 1'b1, 32'hAAAA_0050, 1'b1);
		send_word(OP_DATA, 32'd99, 1'b1, 32'hAAAA_0099, 1'b1);
		send_word(OP_DATA, 32'd100, 1'b1, 32'hAAAA_0100, 1'b1);
		send_word(OP_DATA, 32'd0, 1'b1, 32'h0, 1'b1);
		send_word(OP_DATA, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
		// The word left buffered above survives a new join and drains behind it.
		send_word(OP_SET, 32'd100 + WIN - 2, 1'b0, '0, 1'b0);
		send_word(OP_DATA, 32'd100 + WIN - 2, 1'b1, 32'hAAAA_0130, 1'b1);
		// Wrap of the expected number through zero.
		send_word(OP_SET, 32'hFFFF_FFFE, 1'b1, '0, 1'b0);
		send_word(OP_DATA, 32'hFFFF_FFFF, 1'b1, 32'h8000_0001, 1'b1);
		send_word(OP_DATA, 32'hFFFF_FFFE, 1'b1, 32'h7FFF_FFFE, 1'b1);
		send_word(OP_DATA, 32'h1234_5678, 1'b1, 32'hDEAD_BEEF, 1'b1);
		send_word(OP_DATA, 32'd2, 1'b1, 32'h0000_0002, 1'b1);

		fed     = 0;
		episode = 0;
		while (fed < RANDOM_ITEMS) begin
			run_episode(episode == 2 || $urandom_range(0, 29) == 0);
			episode++;
		end

		s_tvalid <= 1'b0;
		while (tracker.due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		tracker.failures += tracker.due.size();
		if (tracker.failures == 0)
			$display("** sequence_resequencer_core: PASSED **");
		else
			$display("** sequence_resequencer_core: FAILED **");
		$finish;
	end

	// The receiver changes its stall pattern after each random span, and once holds
	// off long enough for the block to fill up and refuse input.
	initial begin
		int mode;
		int span;
		m_tready = 1'b0;
		held_off = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 120);
			for (int i = 0; i < span; i++) begin
				@(posedge clk);
				if (!held_off && tracker != null && tracker.words_seen >= 60) begin
					held_off = 1'b1;
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ((i % 8) < 5);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			tracker.check_word(m_tuser, m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stalled_cycles = 0;
		else
			stalled_cycles++;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("** sequence_resequencer_core: FAILED **");
			$finish;
		end
	end

	initial stalled_cycles = 0;

endmodule
